[rtl/box_downsample_rgb_assert.svh]
// Assertion macros for the box downsampler
`ifndef BOX_DOWNSAMPLE_RGB_ASSERT_SVH
`define BOX_DOWNSAMPLE_RGB_ASSERT_SVH

// clocked property, disabled during reset
`define BDR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("box_downsample_rgb: property failed");

// condition that must never be true
`define BDR_ASSERT_NEVER(lbl, cond) \
  `BDR_ASSERT(lbl, !(cond))

`endif

[rtl/bdr_pkg.sv]
// Types and constants shared by the box downsampler
package bdr_pkg;

  localparam int MaxWidthDef  = 2048;
  localparam int MaxHeightDef = 2048;

  localparam int PixW    = 32;
  localparam int DimW    = 12;
  localparam int ColW    = 14;
  localparam int CoordW  = 11;
  localparam int LaneW   = 12;
  localparam int SumW    = 3 * LaneW;
  localparam int CfgIdxW = 2;
  localparam int ModeW   = 2;

  localparam logic [CfgIdxW-1:0] CfgScaleMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOutWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOutHeight = 2'd2;

  localparam logic [ModeW-1:0] ModeCopy = 2'd0;
  localparam logic [ModeW-1:0] ModeAvg2 = 2'd1;
  localparam logic [ModeW-1:0] ModeAvg4 = 2'd2;

  localparam logic [LaneW:0] Bias = 13'd2;

  typedef struct packed {
    logic [PixW-1:0] src_pixel;
    logic            frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0]   out_pixel;
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic              frame_done;
  } out_item_t;

endpackage

[rtl/box_downsample_rgb.sv]
// Box-filter downsampler by 1, 2 or 4 with a line store of column sums
//
// Source pixels enter on in_valid_i/in_ready_o in raster order, one item per
// clock while in_ready_o is high; frame_start on an item restarts all
// positions. Destination pixels leave on out_valid_o/out_ready_i. Registers
// (scale mode, destination width and height) are written on
// cfg_valid_i/cfg_ready_o; the user must write them only while the block
// is idle, which the block does not enforce. cfg_ready_o is always high.
// The line store is read at the item's destination column at the accepting
// edge; the add, the write-back and the output register follow from the
// stage-one registers. One read-modify-write of the line store per item
// gives one item per clock unless the output stalls; a sum written in the
// same cycle as the next read of that column is forwarded around the memory.
// In copy mode each item leaves unchanged; in the averaging modes an item
// leaves when the last source pixel of its block arrives.
// Reset clears the positions and the registers to copy mode, 1x1 frame. The
// line store needs no clearing: each block starts a fresh sum. When the
// receiver stalls, the output register holds its item, stage two holds, and
// the input stalls once both are full.
module box_downsample_rgb #(
  parameter int MAX_WIDTH  = bdr_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = bdr_pkg::MaxHeightDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bdr_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bdr_pkg::out_item_t             out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bdr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bdr_pkg::DimW-1:0]       cfg_data_i
);
  import bdr_pkg::*;

  localparam int AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [ModeW-1:0] mode_q;
  logic [DimW-1:0]  width_q, height_q;

  logic [DimW-1:0]  w, h;
  logic [1:0]       lg, s_m1;
  logic [ColW-1:0]  line_len;
  logic [ColW-1:0]  col0, col_inc, col_d, col_q;
  logic [1:0]       rib0, rib_d, rib_q;
  logic [2:0]       rib_inc;
  logic [DimW-1:0]  row0, row_d, row_q;
  logic [DimW-1:0]  dx;
  logic [1:0]       sx;
  logic             emit0, done0, clear0;
  logic [AddrW-1:0] addr0;
  logic             in_acc, avg;

  logic             s1_valid_q, s1_emit_q, s1_done_q, s1_clear_q, s1_fin;
  logic [PixW-1:0]  s1_pix_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [CoordW-1:0] s1_x_q, s1_y_q;
  logic             fwd_q, fwd_hit, wr_en;
  logic [SumW-1:0]  fwd_sum_q, rd_q, acc, sum_new;
  logic [LaneW-1:0] l0, l1, l2;
  logic [LaneW:0]   t0, t2;
  logic [PixW-1:0]  res;

  logic             out_valid_q;
  out_item_t        out_q;

  logic [SumW-1:0]  mem [MAX_WIDTH];

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeCopy;
      width_q  <= DimW'(1);
      height_q <= DimW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgScaleMode: mode_q   <= cfg_data_i[ModeW-1:0];
        CfgOutWidth:  width_q  <= cfg_data_i;
        CfgOutHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // geometry
  always_comb begin
    if (width_q == '0)                          w = DimW'(1);
    else if ({20'd0, width_q} > MAX_WIDTH)      w = DimW'(MAX_WIDTH);
    else                                        w = width_q;
    if (height_q == '0)                         h = DimW'(1);
    else if ({20'd0, height_q} > MAX_HEIGHT)    h = DimW'(MAX_HEIGHT);
    else                                        h = height_q;
    case (mode_q)
      ModeAvg2: begin lg = 2'd1; s_m1 = 2'd1; end
      ModeAvg4: begin lg = 2'd2; s_m1 = 2'd3; end
      default:  begin lg = 2'd0; s_m1 = 2'd0; end
    endcase
    line_len = {2'b00, w} << lg;
  end

  assign avg = (lg != 2'd0);

  // stage one: positions and line-store read
  always_comb begin
    col0 = in_item_i.frame_start ? '0 : col_q;
    rib0 = in_item_i.frame_start ? '0 : rib_q;
    row0 = in_item_i.frame_start ? '0 : row_q;
    if (col0 >= line_len)      col0 = '0;
    if (rib0 > s_m1)           rib0 = '0;
    if (row0 >= h)             row0 = '0;
    dx     = DimW'(col0 >> lg);
    sx     = col0[1:0] & s_m1;
    emit0  = (sx == s_m1) && (rib0 == s_m1);
    done0  = emit0 && (dx == w - DimW'(1)) && (row0 == h - DimW'(1));
    clear0 = (sx == 2'd0) && (rib0 == 2'd0);
    addr0  = AddrW'(dx);

    col_inc = col0 + ColW'(1);
    rib_inc = {1'b0, rib0} + 3'd1;
    col_d   = col_inc;
    rib_d   = rib0;
    row_d   = row0;
    if (col_inc >= line_len) begin
      col_d = '0;
      if (rib_inc > {1'b0, s_m1}) begin
        rib_d = '0;
        row_d = (row0 >= h - DimW'(1)) ? '0 : row0 + DimW'(1);
      end else begin
        rib_d = rib_inc[1:0];
      end
    end
  end

  assign s1_fin     = s1_valid_q && (!s1_emit_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fin;
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_en      = s1_fin && avg;
  assign fwd_hit    = wr_en && (s1_addr_q == addr0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      rib_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        col_q      <= col_d;
        rib_q      <= rib_d;
        row_q      <= row_d;
        s1_valid_q <= 1'b1;
        fwd_q      <= fwd_hit;
      end else if (s1_fin) begin
        s1_valid_q <= 1'b0;
        fwd_q      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q   <= in_item_i.src_pixel;
      s1_addr_q  <= addr0;
      s1_x_q     <= dx[CoordW-1:0];
      s1_y_q     <= row0[CoordW-1:0];
      s1_emit_q  <= emit0;
      s1_done_q  <= done0;
      s1_clear_q <= clear0;
      fwd_sum_q  <= sum_new;
    end
  end

  // line store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_addr_q] <= sum_new;
    end
    if (in_acc && avg) begin
      rd_q <= mem[addr0];
    end
  end

  // stage two: accumulate, write back, format
  always_comb begin
    acc = s1_clear_q ? '0 : (fwd_q ? fwd_sum_q : rd_q);
    l0  = acc[LaneW-1:0]         + LaneW'(s1_pix_q[7:0]);
    l1  = acc[2*LaneW-1:LaneW]   + LaneW'(s1_pix_q[15:8]);
    l2  = acc[3*LaneW-1:2*LaneW] + LaneW'(s1_pix_q[23:16]);
    sum_new = {l2, l1, l0};
    t0  = {1'b0, l0} + Bias;
    t2  = {1'b0, l2} + Bias;
    if (!avg) begin
      res = s1_pix_q;
    end else if (lg == 2'd2) begin
      res = {8'h00, t2[11:4], l1[11:4], t0[11:4]};
    end else begin
      res = {8'h00, t2[9:2], l1[9:2], t0[9:2]};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fin && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fin && s1_emit_q) begin
      out_q.out_pixel  <= res;
      out_q.out_x      <= s1_x_q;
      out_q.out_y      <= s1_y_q;
      out_q.frame_done <= s1_done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`include "box_downsample_rgb_assert.svh"

  `BDR_ASSERT(a_emit_loads_out, s1_fin && s1_emit_q |=> out_valid_q)
  `BDR_ASSERT_NEVER(a_write_without_item, wr_en && !s1_valid_q)
  `BDR_ASSERT(a_fwd_needs_item, fwd_q |-> s1_valid_q)

endmodule
